[src/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg: shared types and constants
// Codes, field widths and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_BITS = 6;
  localparam int DIST_BITS = 32;
  localparam int NC_BITS   = 7;
  localparam int KIND_BITS = 2;

  localparam logic [NC_BITS-1:0]   NC_RESET       = 7'd64;
  localparam logic [DIST_BITS-1:0] UNREACHED_DIST = 32'h3F3F3F3F;

  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_RSVD  = 2'd3;

  typedef struct packed {
    logic edge_clr;
    logic edge_add;
    logic q_latch;
    logic q_init;
    logic edge_rd;
    logic node_rd;
    logic relax_en;
    logic apply;
    logic d_rd;
    logic d_lat;
    logic pred_rd;
    logic path_wr_pred;
    logic path_rd;
    logic out_ld_path;
    logic out_ld_unr;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic               bad_query;
    logic               tgt_reached;
    logic               cur_pv;
    logic               out_valid;
    logic               out_xfer;
    logic [NC_BITS-1:0] n_eff;
  } stat_t;

endpackage

[src/bfsp_dp.sv]
// ----------------------------------------------------------------------------
// bfsp_dp: datapath
// Edge list, distance/predecessor/path memories, relaxation arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module bfsp_dp #(
  parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
  parameter int EAW         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ETW         = $clog2(MAX_EDGES + 1),
  parameter int NAW         = $clog2(MAX_NODES)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bfsp_pkg::NC_BITS-1:0]          cfg_wdata,
  input  logic [bfsp_pkg::NODE_BITS-1:0]        edge_source,
  input  logic [bfsp_pkg::NODE_BITS-1:0]        edge_dest,
  input  logic signed [WEIGHT_BITS-1:0]         edge_weight,
  input  logic [bfsp_pkg::NODE_BITS-1:0]        source_node,
  input  logic [bfsp_pkg::NODE_BITS-1:0]        target_node,
  input  bfsp_pkg::cmd_t                        cmd,
  input  logic [EAW-1:0]                        edge_idx,
  input  logic [bfsp_pkg::NC_BITS-1:0]          len,
  input  logic [bfsp_pkg::NC_BITS-1:0]          emit_idx,
  input  logic                                  out_tready,
  output bfsp_pkg::stat_t                       stat,
  output logic [ETW-1:0]                        edge_total,
  output logic                                  out_tvalid,
  output logic [bfsp_pkg::NODE_BITS-1:0]        path_node,
  output logic signed [bfsp_pkg::DIST_BITS-1:0] distance,
  output logic                                  unreachable,
  output logic                                  negative_cycle,
  output logic                                  last
);
  import bfsp_pkg::*;

  localparam logic [NC_BITS-1:0] NMAX = NC_BITS'(MAX_NODES);

  logic [NC_BITS-1:0] nc_r;
  logic [NC_BITS-1:0] n_eff;
  logic [ETW-1:0]     total_r;

  logic [NODE_BITS-1:0]   et_mem [MAX_EDGES];
  logic [NODE_BITS-1:0]   eh_mem [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] ew_mem [MAX_EDGES];
  logic [NODE_BITS-1:0]   et_r, eh_r;
  logic signed [WEIGHT_BITS-1:0] ew_r;

  logic signed [DIST_BITS-1:0] dist_mem [MAX_NODES];
  logic signed [DIST_BITS-1:0] da_r, db_r;
  logic [NAW-1:0]              da_addr;
  logic [NODE_BITS-1:0]        pred_mem [MAX_NODES];
  logic [NODE_BITS-1:0]        pred_r;
  logic [NODE_BITS-1:0]        path_mem [MAX_NODES];
  logic [NODE_BITS-1:0]        path_r;
  logic [NAW-1:0]              path_waddr;
  logic [NODE_BITS-1:0]        path_wdata;

  logic [MAX_NODES-1:0] reached_r, pv_r;
  logic [NODE_BITS-1:0] src_r, dst_r, cur_r;
  logic                 neg_r;
  logic signed [DIST_BITS-1:0] tgt_d_r;

  logic                        edge_ok, relax;
  logic signed [DIST_BITS:0]   sum;
  logic signed [DIST_BITS-1:0] cand;

  logic                        ov_r;
  logic [NODE_BITS-1:0]        onode_r;
  logic signed [DIST_BITS-1:0] odist_r;
  logic                        ounr_r, oneg_r, olast_r;

  assign n_eff = (nc_r == '0) ? NC_BITS'(1) : ((nc_r > NMAX) ? NMAX : nc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_RESET;
    end else if (cfg_we) begin
      nc_r <= cfg_wdata;
    end
  end

  // edge list append / clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.edge_clr) begin
      total_r <= '0;
    end else if (cmd.edge_add && total_r < ETW'(MAX_EDGES)) begin
      total_r <= total_r + ETW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_add && total_r < ETW'(MAX_EDGES)) begin
      et_mem[total_r[EAW-1:0]] <= edge_source;
      eh_mem[total_r[EAW-1:0]] <= edge_dest;
      ew_mem[total_r[EAW-1:0]] <= edge_weight;
    end
    if (cmd.edge_rd) begin
      et_r <= et_mem[edge_idx];
      eh_r <= eh_mem[edge_idx];
      ew_r <= ew_mem[edge_idx];
    end
  end

  // relaxation of the registered edge
  assign edge_ok = (NC_BITS'(et_r) < n_eff) && (NC_BITS'(eh_r) < n_eff)
                   && reached_r[et_r[NAW-1:0]];
  assign sum     = {da_r[DIST_BITS-1], da_r} + (DIST_BITS+1)'(ew_r);
  always_comb begin
    if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
      cand = sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                            : {1'b0, {(DIST_BITS-1){1'b1}}};
    end else begin
      cand = sum[DIST_BITS-1:0];
    end
  end
  assign relax = edge_ok && (!reached_r[eh_r[NAW-1:0]] || cand < db_r);

  assign da_addr = cmd.d_rd ? dst_r[NAW-1:0] : et_r[NAW-1:0];

  // seed the source at zero, then write each applied relaxation
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      dist_mem[src_r[NAW-1:0]] <= '0;
    end else if (cmd.relax_en && cmd.apply && relax) begin
      dist_mem[eh_r[NAW-1:0]] <= cand;
      pred_mem[eh_r[NAW-1:0]] <= et_r;
    end
    if (cmd.node_rd || cmd.d_rd) begin
      da_r <= dist_mem[da_addr];
      db_r <= dist_mem[eh_r[NAW-1:0]];
    end
    if (cmd.pred_rd) begin
      pred_r <= pred_mem[cur_r[NAW-1:0]];
    end
  end

  // path buffer: written during backtrack, read back in reverse
  assign path_waddr = cmd.d_lat ? '0 : len[NAW-1:0];
  assign path_wdata = cmd.d_lat ? dst_r : pred_r;

  always_ff @(posedge clk) begin
    if (cmd.d_lat || cmd.path_wr_pred) begin
      path_mem[path_waddr] <= path_wdata;
    end
    if (cmd.path_rd) begin
      path_r <= path_mem[emit_idx[NAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      src_r <= source_node;
      dst_r <= target_node;
    end
    if (cmd.d_lat) begin
      tgt_d_r <= da_r;
    end
    if (cmd.d_lat) begin
      cur_r <= dst_r;
    end else if (cmd.path_wr_pred) begin
      cur_r <= pred_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      pv_r      <= '0;
      neg_r     <= 1'b0;
    end else begin
      if (cmd.q_latch) begin
        neg_r <= 1'b0;
      end else if (cmd.relax_en && !cmd.apply && relax) begin
        neg_r <= 1'b1;
      end
      if (cmd.q_init) begin
        reached_r                 <= '0;
        reached_r[src_r[NAW-1:0]] <= 1'b1;
        pv_r                      <= '0;
      end else if (cmd.relax_en && cmd.apply && relax) begin
        reached_r[eh_r[NAW-1:0]] <= 1'b1;
        pv_r[eh_r[NAW-1:0]]      <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_ld_path || cmd.out_ld_unr) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld_path) begin
      onode_r <= path_r;
      odist_r <= tgt_d_r;
      ounr_r  <= 1'b0;
      oneg_r  <= neg_r;
      olast_r <= cmd.out_last;
    end else if (cmd.out_ld_unr) begin
      onode_r <= dst_r;
      odist_r <= UNREACHED_DIST;
      ounr_r  <= 1'b1;
      oneg_r  <= neg_r;
      olast_r <= 1'b1;
    end
  end

  assign out_tvalid     = ov_r;
  assign path_node      = onode_r;
  assign distance       = odist_r;
  assign unreachable    = ounr_r;
  assign negative_cycle = oneg_r;
  assign last           = olast_r;
  assign edge_total     = total_r;

  assign stat.bad_query   = (NC_BITS'(src_r) >= n_eff) || (NC_BITS'(dst_r) >= n_eff);
  assign stat.tgt_reached = reached_r[dst_r[NAW-1:0]];
  assign stat.cur_pv      = pv_r[cur_r[NAW-1:0]];
  assign stat.out_valid   = ov_r;
  assign stat.out_xfer    = ov_r && out_tready;
  assign stat.n_eff       = n_eff;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= ETW'(MAX_EDGES))
    else $error("edge count beyond capacity");
  a_init_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_init |=> reached_r[$past(src_r[NAW-1:0])] && pv_r == '0)
    else $error("query init did not seed the source");

endmodule

[src/bfsp_ctrl.sv]
// ----------------------------------------------------------------------------
// bfsp_ctrl: sequencer
// Steps edge loads, relaxation passes, backtracking and result output.
// ----------------------------------------------------------------------------
module bfsp_ctrl #(
  parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF,
  parameter int EAW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ETW       = $clog2(MAX_EDGES + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic [bfsp_pkg::KIND_BITS-1:0]   kind,
  output logic                             in_tready,
  input  bfsp_pkg::stat_t                  stat,
  input  logic [ETW-1:0]                   edge_total,
  output bfsp_pkg::cmd_t                   cmd,
  output logic [EAW-1:0]                   edge_idx,
  output logic [bfsp_pkg::NC_BITS-1:0]     len,
  output logic [bfsp_pkg::NC_BITS-1:0]     emit_idx
);
  import bfsp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QCHK = 4'd1;
  localparam logic [3:0] S_REDG = 4'd2;
  localparam logic [3:0] S_RNOD = 4'd3;
  localparam logic [3:0] S_RCAL = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DLAT = 4'd6;
  localparam logic [3:0] S_BCHK = 4'd7;
  localparam logic [3:0] S_BWT  = 4'd8;
  localparam logic [3:0] S_ERD  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;
  localparam logic [3:0] S_ULD  = 4'd11;
  localparam logic [3:0] S_HOLD = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [EAW-1:0]     e_r, e_nxt;
  logic [NC_BITS-1:0] pass_r, pass_nxt;
  logic [NC_BITS-1:0] len_r, len_nxt;
  logic [NC_BITS-1:0] i_r, i_nxt;
  logic               acc;
  logic               e_last, emit_last;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign e_last    = (ETW'(e_r) + ETW'(1)) == edge_total;
  assign emit_last = (i_r + NC_BITS'(1)) == len_r;
  assign edge_idx  = e_r;
  assign len       = len_r;
  assign emit_idx  = len_r - NC_BITS'(1) - i_r;

  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    pass_nxt  = pass_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.edge_clr = (kind == KIND_CLEAR);
          cmd.edge_add = (kind == KIND_ADD);
          cmd.q_latch  = (kind == KIND_QUERY);
          if (kind == KIND_QUERY) state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (stat.bad_query) begin
          state_nxt = S_ULD;
        end else begin
          cmd.q_init = 1'b1;
          e_nxt      = '0;
          pass_nxt   = '0;
          state_nxt  = (edge_total == '0) ? S_DRD : S_REDG;
        end
      end
      S_REDG: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_RNOD;
      end
      S_RNOD: begin
        cmd.node_rd = 1'b1;
        state_nxt   = S_RCAL;
      end
      S_RCAL: begin
        cmd.relax_en = 1'b1;
        cmd.apply    = (pass_r < stat.n_eff);
        state_nxt    = S_REDG;
        if (e_last) begin
          e_nxt = '0;
          if (pass_r == stat.n_eff) state_nxt = S_DRD;
          else pass_nxt = pass_r + NC_BITS'(1);
        end else begin
          e_nxt = e_r + EAW'(1);
        end
      end
      S_DRD: begin
        cmd.d_rd  = 1'b1;
        state_nxt = S_DLAT;
      end
      S_DLAT: begin
        if (!stat.tgt_reached) begin
          state_nxt = S_ULD;
        end else begin
          cmd.d_lat = 1'b1;
          len_nxt   = NC_BITS'(1);
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (len_r < stat.n_eff && stat.cur_pv) begin
          cmd.pred_rd = 1'b1;
          state_nxt   = S_BWT;
        end else begin
          i_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_BWT: begin
        cmd.path_wr_pred = 1'b1;
        len_nxt          = len_r + NC_BITS'(1);
        state_nxt        = S_BCHK;
      end
      S_ERD: begin
        cmd.path_rd = 1'b1;
        state_nxt   = S_ELD;
      end
      S_ELD: begin
        cmd.out_ld_path = 1'b1;
        cmd.out_last    = emit_last;
        state_nxt       = S_HOLD;
      end
      S_ULD: begin
        cmd.out_ld_unr = 1'b1;
        len_nxt        = NC_BITS'(1);
        i_nxt          = '0;
        state_nxt      = S_HOLD;
      end
      S_HOLD: begin
        if (stat.out_xfer) begin
          i_nxt     = i_r + NC_BITS'(1);
          state_nxt = emit_last ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r     <= '0;
      pass_r  <= '0;
      len_r   <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      e_r     <= e_nxt;
      pass_r  <= pass_nxt;
      len_r   <= len_nxt;
      i_r     <= i_nxt;
    end
  end

  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_valid |-> state_r == S_HOLD)
    else $error("result shown outside hold state");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && kind == KIND_QUERY) |=> !in_tready)
    else $error("input taken during query");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> (i_r < len_r) && (len_r <= stat.n_eff))
    else $error("emit index out of path");

endmodule

[src/bellman_ford_shortest_path.sv]
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path: single-source shortest path engine
// Edge list loader with a Bellman-Ford relaxation sequencer and path output.
// ----------------------------------------------------------------------------
// Load a graph as a stream of edges (tuser kind 1), clear it with kind 0,
// and ask for a path with kind 2. Clear and add are accepted back to back.
// A query holds in_tready low while it runs: every stored edge is relaxed
// node_count times plus one check pass, each edge passing through the edge
// memory read and the two-port distance memory read before it is relaxed.
// The path then streams out source first, one node per transfer, with tlast
// on the final node. An unreachable target or an out-of-range endpoint
// yields a single transfer flagged unreachable.
// Sums saturate to 32 bits. Configure node_count only while the block is idle.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path #(
  parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
  parameter int IN_DW       = ((4 * bfsp_pkg::NODE_BITS + WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: node_count
  input  logic                            cfg_we,
  input  logic [bfsp_pkg::NC_BITS-1:0]    cfg_wdata,
  // input: tuser = kind
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfsp_pkg::KIND_BITS-1:0]  in_tuser,
  // tdata, low bit up: edge_source, edge_dest, edge_weight, source_node,
  // target_node, zero pad
  input  logic [IN_DW-1:0]                in_tdata,
  // result: tlast = last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tlast,
  // tdata, low bit up: path_node, distance, unreachable, negative_cycle
  output logic [39:0]                     out_tdata
);
  import bfsp_pkg::*;

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int W0  = NODE_BITS;
  localparam int W1  = 2 * NODE_BITS;
  localparam int W2  = W1 + WEIGHT_BITS;
  localparam int W3  = W2 + NODE_BITS;
  localparam int W4  = W3 + NODE_BITS;

  cmd_t                        cmd;
  stat_t                       stat;
  logic [EAW-1:0]              edge_idx;
  logic [NC_BITS-1:0]          len;
  logic [NC_BITS-1:0]          emit_idx;
  logic [ETW-1:0]              edge_total;
  logic [NODE_BITS-1:0]        path_node;
  logic signed [DIST_BITS-1:0] distance;
  logic                        unreachable, negative_cycle;

  bfsp_ctrl #(
    .MAX_EDGES (MAX_EDGES), .EAW (EAW), .ETW (ETW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .kind       (in_tuser),
    .in_tready  (in_tready),
    .stat       (stat),
    .edge_total (edge_total),
    .cmd        (cmd),
    .edge_idx   (edge_idx),
    .len        (len),
    .emit_idx   (emit_idx)
  );

  bfsp_dp #(
    .MAX_NODES (MAX_NODES), .MAX_EDGES (MAX_EDGES), .WEIGHT_BITS (WEIGHT_BITS),
    .EAW (EAW), .ETW (ETW), .NAW (NAW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .edge_source    (in_tdata[W0-1:0]),
    .edge_dest      (in_tdata[W1-1:W0]),
    .edge_weight    (in_tdata[W2-1:W1]),
    .source_node    (in_tdata[W3-1:W2]),
    .target_node    (in_tdata[W4-1:W3]),
    .cmd            (cmd),
    .edge_idx       (edge_idx),
    .len            (len),
    .emit_idx       (emit_idx),
    .out_tready     (out_tready),
    .stat           (stat),
    .edge_total     (edge_total),
    .out_tvalid     (out_tvalid),
    .path_node      (path_node),
    .distance       (distance),
    .unreachable    (unreachable),
    .negative_cycle (negative_cycle),
    .last           (out_tlast)
  );

  // pack the result fields, path node in the low bits
  assign out_tdata = {negative_cycle, unreachable, distance, path_node};

endmodule
